FILE: src/pfn_pkg.sv
// Shared constants and trig tables for the fractal gradient noise block.
package pfn_pkg;

    // Fixed field widths.
    localparam int COORD_W = 32;
    localparam int OUT_W   = 25;
    localparam int CNT_W   = 4;

    // Rotation constants are Q.16 values in an 18-bit signed word.
    localparam int TRIG_W    = 18;
    localparam int TRIG_BITS = 16;

    // Rotated coordinate before scaling, and the biased dividend.
    localparam int UW  = 50;
    localparam int DVW = 54;

    // Divide-by-35 unit: divisor and quotient bits produced per cycle.
    localparam int DIVISOR   = 35;
    localparam int DIV_DIGIT = 16;

    // Each quotient digit is the partial dividend times a rounded-up
    // reciprocal of the divisor, shifted down; the extra precision keeps
    // the digit exact over the whole range of partial dividends.
    localparam int     DIV_RECIP_SH = DIV_DIGIT + 12;
    localparam longint DIV_RECIP    = ((longint'(1) << DIV_RECIP_SH) + DIVISOR - 1) / DIVISOR;

    // Bias that makes the dividend non-negative; it only touches quotient
    // bits above the ones that are used.
    localparam logic [DVW-1:0] DIV_OFFSET = DVW'(DIVISOR) << 48;

    // Saturation limits of the result.
    localparam int OUT_MAX = (1 << 24) - 1;
    localparam int OUT_MIN = -(1 << 24);

    typedef logic signed [TRIG_W-1:0] t_trig;

    // Cosine of the rotation used by octave k.
    function automatic t_trig trig_cos(input logic [3:0] k);
        t_trig c;
        case (k)
            4'd0, 4'd1, 4'd11, 4'd13: c = 18'sd56756;
            4'd2, 4'd10, 4'd14:       c = 18'sd32768;
            4'd3, 4'd9, 4'd15:        c = 18'sd0;
            4'd4, 4'd8:               c = -18'sd32768;
            4'd5, 4'd7:               c = -18'sd56756;
            4'd6:                     c = -18'sd65536;
            4'd12:                    c = 18'sd65536;
            default:                  c = 18'sd0;
        endcase
        return c;
    endfunction

    // Sine of the rotation used by octave k.
    function automatic t_trig trig_sin(input logic [3:0] k);
        t_trig s;
        case (k)
            4'd0, 4'd1, 4'd5, 4'd13: s = 18'sd32768;
            4'd2, 4'd4, 4'd14:       s = 18'sd56756;
            4'd3, 4'd15:             s = 18'sd65536;
            4'd6, 4'd12:             s = 18'sd0;
            4'd7, 4'd11:             s = -18'sd32768;
            4'd8, 4'd10:             s = -18'sd56756;
            4'd9:                    s = -18'sd65536;
            default:                 s = 18'sd0;
        endcase
        return s;
    endfunction

endpackage

FILE: src/pfn_ram.sv
// Generic single-port RAM with a registered read.
module pfn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port share one address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/pfn_div35.sv
// Divider by the constant 35, one reciprocal-multiply quotient digit per cycle.
module pfn_div35 #(
    parameter int VW = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [VW-1:0] i_dividend,
    output logic          o_busy,
    output logic [VW-1:0] o_quot
);

    localparam int STEPS = VW / pfn_pkg::DIV_DIGIT;
    localparam int CW    = $clog2(STEPS + 1);
    localparam int DG    = pfn_pkg::DIV_DIGIT;
    localparam int TW    = DG + 6;
    localparam int MW    = pfn_pkg::DIV_RECIP_SH - 5;
    localparam int PW    = TW + MW;
    localparam logic [MW-1:0] RECIP = MW'(pfn_pkg::DIV_RECIP);

    logic [VW-1:0] r_work;
    logic [5:0]    r_rem;
    logic [CW-1:0] r_cnt;
    logic [VW-1:0] n_work;
    logic [5:0]    n_rem;
    logic [TW-1:0] part;
    logic [PW-1:0] part_prod;
    logic [DG-1:0] digit;
    logic [TW-1:0] digit_back;

    // The running remainder and the next dividend digit form the partial
    // dividend. Its quotient digit comes from the scaled reciprocal, and the
    // new remainder is what is left after taking the digit times 35 away.
    // Quotient digits enter at the bottom as dividend digits leave at the top.
    assign part       = {r_rem, r_work[VW-1 -: DG]};
    assign part_prod  = PW'(part) * PW'(RECIP);
    assign digit      = part_prod[pfn_pkg::DIV_RECIP_SH +: DG];
    assign digit_back = TW'(digit) * TW'(pfn_pkg::DIVISOR);
    assign n_rem      = 6'(part - digit_back);
    assign n_work     = {r_work[VW-DG-1:0], digit};

    // Step counter and work registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt  <= CW'(STEPS);
            r_work <= i_dividend;
            r_rem  <= '0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_work;

endmodule

FILE: src/perlin_fbm_noise_2d.sv
// Fractal 2D gradient noise: top level with sequencer and shared multiplier.
//
// A load transfer (req_type 0) writes one byte of the permutation table in
// the cycle it is accepted and gives no result. A query transfer (req_type 1)
// sums octave_count octaves (clamped to MAX_OCTAVES) and gives one result.
// Queries are handled one at a time. Each octave runs in turn the rotation,
// the launch of the two divide-by-35 units, the division, the six dependent
// table lookups, the corner gradients, both fade polynomials and the blends.
// The dividers work on a dividend of VW bits (64 at the defaults) and make
// one 16-bit quotient digit per cycle. The steps run one after another since
// one shared multiplier runs the rotation, both fade polynomials and the
// three blends in turn, and the table RAM is single-port. A query that
// finishes while the previous result still waits in the output register is
// held until that register is free. The input is stalled while a query runs;
// a finished result waits in the output register while new transfers are
// taken. The table has no reset; every entry a query touches must have been
// loaded first.
module perlin_fbm_noise_2d #(
    parameter int PERM_SIZE   = 256,
    parameter int MAX_OCTAVES = 8,
    parameter int FRAC_BITS   = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_req_type,
    input  logic [$clog2(PERM_SIZE)-1:0]     i_perm_index,
    input  logic [$clog2(PERM_SIZE)-1:0]     i_perm_value,
    input  logic signed [pfn_pkg::COORD_W-1:0] i_x_coord,
    input  logic signed [pfn_pkg::COORD_W-1:0] i_y_coord,
    input  logic [pfn_pkg::CNT_W-1:0]        i_octave_count,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [pfn_pkg::OUT_W-1:0] o_noise_value
);

    localparam int PAW   = $clog2(PERM_SIZE);
    localparam int OW    = $clog2(MAX_OCTAVES + 1);
    localparam int AW    = 33;
    localparam int BW    = ((FRAC_BITS > 16) ? FRAC_BITS : 16) + 3;
    localparam int PW    = AW + BW;
    localparam int NW    = FRAC_BITS + 4;
    localparam int FW    = FRAC_BITS + 2;
    localparam int EW    = NW + 7;
    localparam int ACC_W = (FRAC_BITS + 15 > 26) ? FRAC_BITS + 15 : 26;
    localparam int CW    = PAW + FRAC_BITS;
    localparam int VW    = ((pfn_pkg::DVW + MAX_OCTAVES - 1 + pfn_pkg::DIV_DIGIT - 1)
                            / pfn_pkg::DIV_DIGIT) * pfn_pkg::DIV_DIGIT;

    localparam logic signed [AW-1:0] FIX_15 = AW'(15) <<< FRAC_BITS;
    localparam logic signed [AW-1:0] FIX_10 = AW'(10) <<< FRAC_BITS;
    localparam logic signed [NW-1:0] FIX_1  = NW'(1) <<< FRAC_BITS;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(pfn_pkg::OUT_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(pfn_pkg::OUT_MIN);

    typedef enum logic [3:0] {
        S_IDLE, S_ROT, S_DIVGO, S_DIVW, S_RD, S_DOT, S_FADE, S_LERP, S_DONE
    } t_state;

    t_state                  r_state;
    logic [2:0]              r_step;
    logic [OW-1:0]           r_k;
    logic [OW-1:0]           r_oct;
    logic signed [AW-1:0]    r_x;
    logic signed [AW-1:0]    r_y;
    logic signed [AW-1:0]    r_ma;
    logic signed [BW-1:0]    r_mb;
    logic signed [pfn_pkg::UW-1:0] r_ux;
    logic signed [pfn_pkg::UW-1:0] r_uy;
    logic [CW-1:0]           r_cx;
    logic [CW-1:0]           r_cy;
    logic [PAW-1:0]          r_px0;
    logic [PAW-1:0]          r_px1;
    logic [1:0]              r_h [4];
    logic signed [NW-1:0]    r_dbl;
    logic signed [NW-1:0]    r_dtl;
    logic signed [NW-1:0]    r_dbr;
    logic signed [NW-1:0]    r_dtr;
    logic signed [FW-1:0]    r_fu;
    logic signed [NW-1:0]    r_l1;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_o_valid;
    logic signed [pfn_pkg::OUT_W-1:0] r_o_noise;

    logic signed [PW-1:0]    prod;
    logic signed [AW-1:0]    prod_sh;
    logic                    accept;
    logic                    ram_we;
    logic [PAW-1:0]          ram_addr;
    logic [PAW-1:0]          ram_rdata;
    logic [pfn_pkg::DVW-1:0] dvx;
    logic [pfn_pkg::DVW-1:0] dvy;
    logic [VW-1:0]           vx;
    logic [VW-1:0]           vy;
    logic [VW-1:0]           qx;
    logic [VW-1:0]           qy;
    logic                    busy_x;
    logic                    busy_y;
    logic                    div_start;
    logic [PAW-1:0]          x0;
    logic [PAW-1:0]          y0;
    logic [FRAC_BITS-1:0]    xf;
    logic [FRAC_BITS-1:0]    yf;
    logic signed [NW-1:0]    dx0;
    logic signed [NW-1:0]    dx1;
    logic signed [NW-1:0]    dy0;
    logic signed [NW-1:0]    dy1;
    logic signed [NW-1:0]    l2;
    logic signed [NW-1:0]    nval;
    logic signed [EW-1:0]    term;
    logic signed [ACC_W-1:0] acc_sum;
    logic [OW-1:0]           k_next;

    // Dot product of a corner offset with one of four diagonal gradients.
    function automatic logic signed [NW-1:0] grad_dot(
        input logic [1:0] h,
        input logic signed [NW-1:0] dx,
        input logic signed [NW-1:0] dy
    );
        logic signed [NW-1:0] r;
        case (h)
            2'd0:    r = dx + dy;
            2'd1:    r = dy - dx;
            2'd2:    r = -dx - dy;
            default: r = dx - dy;
        endcase
        return r;
    endfunction

    // Shared multiplier; the product is taken back to the noise format.
    assign prod    = r_ma * r_mb;
    assign prod_sh = prod[FRAC_BITS +: AW];

    assign accept  = i_valid && (r_state == S_IDLE);
    assign o_stall = (r_state != S_IDLE);

    // Cell indices and fractions of the scaled coordinate.
    assign x0 = r_cx[FRAC_BITS +: PAW];
    assign y0 = r_cy[FRAC_BITS +: PAW];
    assign xf = r_cx[FRAC_BITS-1:0];
    assign yf = r_cy[FRAC_BITS-1:0];
    assign dx0 = NW'(xf);
    assign dy0 = NW'(yf);
    assign dx1 = NW'(xf) - FIX_1;
    assign dy1 = NW'(yf) - FIX_1;

    // Blend results and the weighted octave term.
    assign l2      = r_dbr + prod_sh[NW-1:0];
    assign nval    = r_l1 + prod_sh[NW-1:0];
    assign term    = ((EW'(nval) <<< 6) + EW'(nval)) >>> r_k;
    assign acc_sum = r_acc + ACC_W'(term);
    assign k_next  = r_k + 1'b1;

    // Table port: loads in idle, the lookup chain in the read state.
    assign ram_we = accept && !i_req_type;
    always_comb begin
        ram_addr = i_perm_index;
        if (r_state == S_RD) begin
            case (r_step)
                3'd0:    ram_addr = x0;
                3'd1:    ram_addr = x0 + 1'b1;
                3'd2:    ram_addr = r_px0 + y0;
                3'd3:    ram_addr = r_px0 + y0 + 1'b1;
                3'd4:    ram_addr = r_px1 + y0;
                3'd5:    ram_addr = r_px1 + y0 + 1'b1;
                default: ram_addr = x0;
            endcase
        end
    end

    pfn_ram #(
        .WIDTH(PAW),
        .DEPTH(PERM_SIZE)
    ) u_perm (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(i_perm_value),
        .o_rdata(ram_rdata)
    );

    // Biased dividends for floor(u * 2^k / 35).
    assign div_start = (r_state == S_DIVGO);
    assign dvx = pfn_pkg::DVW'(r_ux) + pfn_pkg::DIV_OFFSET;
    assign dvy = pfn_pkg::DVW'(r_uy) + pfn_pkg::DIV_OFFSET;
    assign vx  = VW'(dvx) << r_k;
    assign vy  = VW'(dvy) << r_k;

    pfn_div35 #(.VW(VW)) u_div_x (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(vx),
        .o_busy    (busy_x),
        .o_quot    (qx)
    );

    pfn_div35 #(.VW(VW)) u_div_y (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(vy),
        .o_busy    (busy_y),
        .o_quot    (qy)
    );

    // Sequencer with its datapath registers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_k       <= '0;
            r_oct     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            // The finishing state reloads the output register itself.
            if (r_o_valid && !i_stall && (r_state != S_DONE)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && i_req_type) begin
                        r_x   <= AW'(i_x_coord);
                        r_y   <= AW'(i_y_coord);
                        r_ma  <= AW'(i_x_coord);
                        r_mb  <= BW'(pfn_pkg::trig_cos(4'd0));
                        r_k   <= '0;
                        r_acc <= '0;
                        r_step <= '0;
                        if (int'(i_octave_count) > MAX_OCTAVES) begin
                            r_oct <= OW'(MAX_OCTAVES);
                        end else begin
                            r_oct <= OW'(i_octave_count);
                        end
                        if (i_octave_count == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_ROT;
                        end
                    end
                end
                S_ROT: begin
                    r_step <= r_step + 1'b1;
                    case (r_step)
                        3'd0: begin
                            r_ux <= prod[pfn_pkg::UW-1:0];
                            r_ma <= r_y;
                            r_mb <= BW'(pfn_pkg::trig_sin(4'(r_k)));
                        end
                        3'd1: begin
                            r_ux <= r_ux + prod[pfn_pkg::UW-1:0];
                            r_ma <= r_y;
                            r_mb <= BW'(pfn_pkg::trig_cos(4'(r_k)));
                        end
                        3'd2: begin
                            r_uy <= prod[pfn_pkg::UW-1:0];
                            r_ma <= r_x;
                            r_mb <= BW'(pfn_pkg::trig_sin(4'(r_k)));
                        end
                        default: begin
                            r_uy    <= r_uy - prod[pfn_pkg::UW-1:0];
                            r_state <= S_DIVGO;
                        end
                    endcase
                end
                S_DIVGO: begin
                    r_state <= S_DIVW;
                end
                S_DIVW: begin
                    if (!busy_x) begin
                        r_cx    <= qx[pfn_pkg::TRIG_BITS +: CW];
                        r_cy    <= qy[pfn_pkg::TRIG_BITS +: CW];
                        r_step  <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    // Each step takes the byte addressed in the step before.
                    r_step <= r_step + 1'b1;
                    case (r_step)
                        3'd1:    r_px0 <= ram_rdata;
                        3'd2:    r_px1 <= ram_rdata;
                        3'd3:    r_h[0] <= ram_rdata[1:0];
                        3'd4:    r_h[1] <= ram_rdata[1:0];
                        3'd5:    r_h[2] <= ram_rdata[1:0];
                        3'd6: begin
                            r_h[3]  <= ram_rdata[1:0];
                            r_state <= S_DOT;
                        end
                        default: r_px0 <= r_px0;
                    endcase
                end
                S_DOT: begin
                    r_dbl   <= grad_dot(r_h[0], dx0, dy0);
                    r_dtl   <= grad_dot(r_h[1], dx0, dy1);
                    r_dbr   <= grad_dot(r_h[2], dx1, dy0);
                    r_dtr   <= grad_dot(r_h[3], dx1, dy1);
                    r_ma    <= (AW'(xf) <<< 2) + (AW'(xf) <<< 1) - FIX_15;
                    r_mb    <= BW'(xf);
                    r_step  <= '0;
                    r_state <= S_FADE;
                end
                S_FADE: begin
                    // Quintic fade of xf in steps 0-3, of yf in steps 4-7.
                    r_step <= r_step + 1'b1;
                    case (r_step)
                        3'd0, 3'd4: r_ma <= prod_sh + FIX_10;
                        3'd3: begin
                            r_fu <= prod_sh[FW-1:0];
                            r_ma <= (AW'(yf) <<< 2) + (AW'(yf) <<< 1) - FIX_15;
                            r_mb <= BW'(yf);
                        end
                        3'd7: begin
                            r_ma    <= AW'(r_dtl - r_dbl);
                            r_mb    <= BW'(prod_sh[FW-1:0]);
                            r_step  <= '0;
                            r_state <= S_LERP;
                        end
                        default: r_ma <= prod_sh;
                    endcase
                end
                S_LERP: begin
                    r_step <= r_step + 1'b1;
                    case (r_step)
                        3'd0: begin
                            r_l1 <= r_dbl + prod_sh[NW-1:0];
                            r_ma <= AW'(r_dtr - r_dbr);
                        end
                        3'd1: begin
                            r_ma <= AW'(l2 - r_l1);
                            r_mb <= BW'(r_fu);
                        end
                        default: begin
                            r_acc  <= acc_sum;
                            r_k    <= k_next;
                            r_step <= '0;
                            r_ma   <= r_x;
                            r_mb   <= BW'(pfn_pkg::trig_cos(4'(k_next)));
                            if (k_next == r_oct) begin
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_ROT;
                            end
                        end
                    endcase
                end
                S_DONE: begin
                    // Saturate into the output register once it is free.
                    if (!r_o_valid || !i_stall) begin
                        r_o_valid <= 1'b1;
                        if (r_acc > SAT_HI) begin
                            r_o_noise <= pfn_pkg::OUT_W'(pfn_pkg::OUT_MAX);
                        end else if (r_acc < SAT_LO) begin
                            r_o_noise <= pfn_pkg::OUT_W'(pfn_pkg::OUT_MIN);
                        end else begin
                            r_o_noise <= r_acc[pfn_pkg::OUT_W-1:0];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_o_valid;
    assign o_noise_value = r_o_noise;

    // A result appears only when a query finishes.
    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the finishing state");

    // Both dividers start together when the sequencer launches them.
    a_div_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVGO) |=> (busy_x && busy_y))
        else $error("dividers did not start");

    // The two dividers always run in lockstep.
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy_x == busy_y)
        else $error("dividers out of step");

    // While an octave is in work its index stays below the octave count.
    a_octave_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_DONE) |-> (r_k < r_oct))
        else $error("octave index past the count");

endmodule
